### hw/rtl/vmfc_pkg.sv
package vmfc_pkg;

  // Default sizes of the sample history and of the frame
  localparam int DEF_MAX_TAPS  = 15;
  localparam int DEF_MAX_FRAME = 4096;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int TAP_W      = 16;
  localparam int TAP_COUNT  = 15;
  localparam int OUT_W      = 24;
  localparam int POS_W      = 12;
  localparam int KLEN_W     = 4;
  localparam int FLEN_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TAPS3_W    = 48;

  // Arithmetic: Q1.15 x Q5.11 products, Q.26 sum, Q.15 result
  localparam int PROD_W     = SAMPLE_W + TAP_W;
  localparam int ACC_W      = PROD_W + 4;
  localparam int FRAC_SHIFT = 11;

  localparam logic signed [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};

  // Register reset values
  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd5;
  localparam logic [FLEN_W-1:0] FLEN_RESET = 13'd64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_TAPS   = 3'd0,
    CFG_FRAME_LENGTH  = 3'd1,
    CFG_TAPS_0_3      = 3'd2,
    CFG_TAPS_4_7      = 3'd3,
    CFG_TAPS_8_11     = 3'd4,
    CFG_TAPS_12_14    = 3'd5
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT,
    ST_TAIL
  } state_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  // Rounded and clipped sum from the multiply-accumulate unit
  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    saturated;
  } mac_result_t;

endpackage

### hw/rtl/valid_mode_fir_convolver_unit.sv
// Valid-mode FIR convolver (correlation form, taps not flipped).
//
// Samples arrive on the sample channel (sample_valid / sample_stall) and
// results leave on the result channel (result_valid / result_stall); a
// transfer happens at a clock edge with valid high and stall low. The
// configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while the block is idle.
//
// One shared multiplier steps through the taps of the kernel, one tap a
// cycle, into a product register and an accumulator. With K taps in use,
// a sample that produces a filtered value steps through all K taps in the
// MAC state, then DRAIN and EMIT, before the block takes the next sample;
// the result is loaded into the output register from EMIT. At the last sample of a
// frame each unreachable tail position adds one more result.
// A sample that produces no result leaves the block idle, ready for the next one.
//
// The result sits in an output register; while the receiver stalls it
// holds, and the sequencer waits before loading the next one. Synchronous
// reset clears the sample history, the frame count and the result valid,
// and loads a 5-tap kernel, frame_length 64 and all taps zero.
module valid_mode_fir_convolver_unit
  import vmfc_pkg::*;
#(
  parameter int MAX_TAPS  = DEF_MAX_TAPS,
  parameter int MAX_FRAME = DEF_MAX_FRAME
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic signed [SAMPLE_W-1:0]   sample,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [OUT_W-1:0]      filtered,
  output logic        [POS_W-1:0]      out_position,
  output logic                         saturated,
  output logic                         frame_end
);

  localparam int CW = $clog2(MAX_FRAME);
  localparam int FW = $clog2(MAX_FRAME + 1);

  // Configuration registers
  logic [KLEN_W-1:0]     kernel_taps;
  logic [FLEN_W-1:0]     frame_length;
  logic [CFG_DATA_W-1:0] taps_0_to_3;
  logic [CFG_DATA_W-1:0] taps_4_to_7;
  logic [CFG_DATA_W-1:0] taps_8_to_11;
  logic [TAPS3_W-1:0]    taps_12_to_14;
  logic [TAP_W*TAP_COUNT-1:0] tap_bits;

  // Sequencer state
  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [KLEN_W-1:0] k_r, k_next;
  logic [FW-1:0]     f_r, f_next;
  logic [KLEN_W-1:0] tap_i, tap_i_next;
  logic [FW-1:0]     tail_pos, tail_pos_next;
  logic [POS_W-1:0]  val_pos, val_pos_next;
  logic              tail_any, tail_any_next;
  logic              frame_done, frame_done_next;

  // Per-sample decode
  logic              accept;
  logic [KLEN_W-1:0] k_eff;
  logic [FW-1:0]     f_eff;
  logic [CW-1:0]     n_eff;
  logic [CW:0]       n_inc;
  logic              do_val;
  logic              do_tail;

  // Datapath links
  mac_ctrl_t                  mac_ctrl;
  mac_result_t                mac_res;
  logic signed [TAP_W-1:0]    tap_word;
  logic signed [SAMPLE_W-1:0] hist_word;
  logic        [KLEN_W-1:0]   hist_idx;

  // Output register
  logic                    slot_free;
  logic                    out_load;
  logic signed [OUT_W-1:0] filtered_next;
  logic [POS_W-1:0]        out_position_next;
  logic                    saturated_next;
  logic                    frame_end_next;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_taps   <= KLEN_RESET;
      frame_length  <= FLEN_RESET;
      taps_0_to_3   <= '0;
      taps_4_to_7   <= '0;
      taps_8_to_11  <= '0;
      taps_12_to_14 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_KERNEL_TAPS:   kernel_taps   <= cfg_data[KLEN_W-1:0];
        CFG_FRAME_LENGTH:  frame_length  <= cfg_data[FLEN_W-1:0];
        CFG_TAPS_0_3:      taps_0_to_3   <= cfg_data;
        CFG_TAPS_4_7:      taps_4_to_7   <= cfg_data;
        CFG_TAPS_8_11:     taps_8_to_11  <= cfg_data;
        CFG_TAPS_12_14:    taps_12_to_14 <= cfg_data[TAPS3_W-1:0];
        default: ;
      endcase
    end
  end

  assign tap_bits = {taps_12_to_14, taps_8_to_11, taps_4_to_7, taps_0_to_3};

  // Clamp lengths and place the arriving sample in its frame
  always_comb begin
    if (kernel_taps == '0) begin
      k_eff = KLEN_W'(1);
    end else if (kernel_taps > MAX_TAPS) begin
      k_eff = KLEN_W'(MAX_TAPS);
    end else begin
      k_eff = kernel_taps;
    end
    if (frame_length == '0) begin
      f_eff = FW'(1);
    end else if (frame_length > MAX_FRAME) begin
      f_eff = FW'(MAX_FRAME);
    end else begin
      f_eff = FW'(frame_length);
    end
    n_eff   = (count >= f_eff) ? '0 : count;
    n_inc   = {1'b0, n_eff} + 1'b1;
    do_val  = n_inc >= (CW+1)'(k_eff);
    do_tail = n_inc == (CW+1)'(f_eff);
  end

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign slot_free    = !result_valid || !result_stall;

  // Operand selection for the shared multiplier
  assign tap_word = tap_bits[TAP_W*tap_i +: TAP_W];
  assign hist_idx = k_r - KLEN_W'(1) - tap_i;

  vmfc_history #(
    .DEPTH (MAX_TAPS)
  ) u_history (
    .clk      (clk),
    .rst      (rst),
    .shift_en (accept),
    .din      (sample),
    .rd_idx   (hist_idx),
    .rd_data  (hist_word)
  );

  vmfc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .tap    (tap_word),
    .smp    (hist_word),
    .result (mac_res)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_next;
    f_r        <= f_next;
    tap_i      <= tap_i_next;
    tail_pos   <= tail_pos_next;
    val_pos    <= val_pos_next;
    tail_any   <= tail_any_next;
    frame_done <= frame_done_next;
  end

  // Next state, multiplier control and output loads
  always_comb begin
    state_next        = state;
    count_next        = count;
    k_next            = k_r;
    f_next            = f_r;
    tap_i_next        = tap_i;
    tail_pos_next     = tail_pos;
    val_pos_next      = val_pos;
    tail_any_next     = tail_any;
    frame_done_next   = frame_done;
    mac_ctrl          = '0;
    out_load          = 1'b0;
    filtered_next     = '0;
    out_position_next = '0;
    saturated_next    = 1'b0;
    frame_end_next    = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          mac_ctrl.clear  = 1'b1;
          k_next          = k_eff;
          f_next          = f_eff;
          tap_i_next      = '0;
          val_pos_next    = POS_W'(n_inc - (CW+1)'(k_eff));
          frame_done_next = do_tail;
          tail_any_next   = do_tail && (k_eff != KLEN_W'(1));
          tail_pos_next   = ((CW+1)'(k_eff) <= (CW+1)'(f_eff)) ?
                            f_eff - FW'(k_eff) + FW'(1) : '0;
          count_next      = do_tail ? '0 : n_inc[CW-1:0];
          if (do_val) begin
            state_next = ST_MAC;
          end else if (do_tail) begin
            state_next = ST_TAIL;
          end
        end
      end

      ST_MAC: begin
        mac_ctrl.issue = 1'b1;
        tap_i_next     = tap_i + KLEN_W'(1);
        if (tap_i == k_r - KLEN_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_load          = 1'b1;
          filtered_next     = mac_res.value;
          out_position_next = val_pos;
          saturated_next    = mac_res.saturated;
          frame_end_next    = frame_done && !tail_any;
          state_next        = tail_any ? ST_TAIL : ST_IDLE;
        end
      end

      ST_TAIL: begin
        if (slot_free) begin
          out_load          = 1'b1;
          out_position_next = POS_W'(tail_pos);
          frame_end_next    = (tail_pos == f_r - FW'(1));
          tail_pos_next     = tail_pos + FW'(1);
          if (frame_end_next) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: load when free, drop valid after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered     <= filtered_next;
      out_position <= out_position_next;
      saturated    <= saturated_next;
      frame_end    <= frame_end_next;
    end
  end

endmodule

### hw/rtl/vmfc_history.sv
module vmfc_history
  import vmfc_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_TAPS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift_en,
  input  logic signed [SAMPLE_W-1:0] din,
  input  logic        [KLEN_W-1:0]   rd_idx,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [SAMPLE_W-1:0] hist [DEPTH];
  logic        [IW-1:0]       idx;

  // Shift the newest sample in at the head
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DEPTH; j++) begin
        hist[j] <= '0;
      end
    end else if (shift_en) begin
      hist[0] <= din;
      for (int j = 1; j < DEPTH; j++) begin
        hist[j] <= hist[j-1];
      end
    end
  end

  // Select one entry for the multiplier
  assign idx     = IW'(rd_idx);
  assign rd_data = hist[idx];

endmodule

### hw/rtl/vmfc_mac.sv
module vmfc_mac
  import vmfc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctrl_t                  ctrl,
  input  logic signed [TAP_W-1:0]    tap,
  input  logic signed [SAMPLE_W-1:0] smp,
  output mac_result_t                result
);

  localparam int QW = ACC_W - FRAC_SHIFT;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;
  logic signed [QW-1:0]     q;
  logic        [QW-OUT_W:0] q_top;

  // Register the product before it is summed
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ctrl.clear) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod <= tap * smp;
    end
  end

  // Accumulate one product a cycle
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Floor to Q.15 and clip to the output range
  always_comb begin
    q     = acc[ACC_W-1:FRAC_SHIFT];
    q_top = q[QW-1:OUT_W-1];
    if ((&q_top) || !(|q_top)) begin
      result.value     = q[OUT_W-1:0];
      result.saturated = 1'b0;
    end else begin
      result.value     = q[QW-1] ? SAT_LO : SAT_HI;
      result.saturated = 1'b1;
    end
  end

endmodule

### hw/rtl/vmfc_checker.sv
module vmfc_protocol_checker
  import vmfc_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    result_valid,
  input logic                    result_stall,
  input logic signed [OUT_W-1:0] filtered,
  input logic        [POS_W-1:0] out_position,
  input logic                    saturated,
  input logic                    frame_end
);

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // Hold a stalled result
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(filtered)
      && $stable(out_position) && $stable(saturated) && $stable(frame_end))
    else $error("stalled result changed");

  // A clipped result sits at one end of the range
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> filtered == SAT_HI || filtered == SAT_LO)
    else $error("saturated flag with value inside range");

endmodule

bind valid_mode_fir_convolver_unit vmfc_protocol_checker u_vmfc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .filtered     (filtered),
  .out_position (out_position),
  .saturated    (saturated),
  .frame_end    (frame_end)
);

### bench/vmfc_checker.sv
module vmfc_checker
  import vmfc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  input  logic                         sample_valid,
  input  logic                         sample_stall,
  input  logic signed [SAMPLE_W-1:0]   sample,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  logic signed [OUT_W-1:0]      filtered,
  input  logic        [POS_W-1:0]      out_position,
  input  logic                         saturated,
  input  logic                         frame_end,
  output int                           fail_count,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic        [POS_W-1:0] position;
    logic                    saturated;
    logic                    frame_end;
  } conv_output_t;

  conv_output_t expected_outputs[$];

  // Shadow copy of the registers and of the filter state
  logic        [KLEN_W-1:0]     kernel_len;
  logic        [FLEN_W-1:0]     frame_len;
  logic        [CFG_DATA_W-1:0] tap_bank[4];
  logic signed [SAMPLE_W-1:0]   history[TAP_COUNT];
  int                           frame_count;
  int                           mismatches = 0;

  function automatic logic signed [TAP_W-1:0] tap_value(int i);
    if (i >= TAP_COUNT) return '0;
    return tap_bank[i / 4][TAP_W * (i % 4) +: TAP_W];
  endfunction

  task automatic report(string msg);
    $display("%0t ns  mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Shift in one sample and queue the outputs it causes
  task automatic convolve_sample(logic signed [SAMPLE_W-1:0] s);
    int           k;
    int           f;
    int           n;
    int           start;
    bit           ends;
    longint       acc;
    longint       q;
    conv_output_t item;
    k = (kernel_len == 0) ? 1 : int'(kernel_len);
    f = (frame_len == 0) ? 1 : int'(frame_len);
    if (f > DEF_MAX_FRAME) f = DEF_MAX_FRAME;
    n = (frame_count >= f) ? 0 : frame_count;
    for (int j = TAP_COUNT - 1; j > 0; j--) history[j] = history[j - 1];
    history[0] = s;
    ends  = (n + 1 >= f);
    start = (k <= f) ? f - k + 1 : 0;

    // Valued output once the kernel fits
    if (n + 1 >= k) begin
      acc = 0;
      for (int i = 0; i < k; i++)
        acc += longint'(tap_value(i)) * longint'(history[k - 1 - i]);
      q = acc >>> FRAC_SHIFT;
      item.saturated = 1'b0;
      if (q > longint'(SAT_HI)) begin
        q = longint'(SAT_HI);
        item.saturated = 1'b1;
      end
      if (q < longint'(SAT_LO)) begin
        q = longint'(SAT_LO);
        item.saturated = 1'b1;
      end
      item.filtered  = OUT_W'(q);
      item.position  = POS_W'(n + 1 - k);
      item.frame_end = ends && (start >= f);
      expected_outputs.push_back(item);
    end

    // Zero tail at the end of the frame
    if (ends) begin
      for (int p = start; p < f; p++) begin
        item.filtered  = '0;
        item.position  = POS_W'(p);
        item.saturated = 1'b0;
        item.frame_end = (p == f - 1);
        expected_outputs.push_back(item);
      end
      frame_count = 0;
    end else begin
      frame_count = n + 1;
    end
  endtask

  task automatic check_result();
    conv_output_t want;
    if (expected_outputs.size() == 0) begin
      report($sformatf("result pos %0d with no output expected", out_position));
    end else begin
      want = expected_outputs.pop_front();
      if (filtered !== want.filtered)
        report($sformatf("pos %0d filtered %0d, want %0d",
                         want.position, filtered, want.filtered));
      if (out_position !== want.position)
        report($sformatf("out_position %0d, want %0d", out_position, want.position));
      if (saturated !== want.saturated)
        report($sformatf("pos %0d saturated %0b, want %0b",
                         want.position, saturated, want.saturated));
      if (frame_end !== want.frame_end)
        report($sformatf("pos %0d frame_end %0b, want %0b",
                         want.position, frame_end, want.frame_end));
    end
  endtask

  // Watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      kernel_len  = KLEN_RESET;
      frame_len   = FLEN_RESET;
      frame_count = 0;
      for (int i = 0; i < 4; i++) tap_bank[i] = '0;
      for (int i = 0; i < TAP_COUNT; i++) history[i] = '0;
      expected_outputs.delete();
    end else begin
      if (result_valid && !result_stall) check_result();
      if (sample_valid && !sample_stall) convolve_sample(sample);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KERNEL_TAPS:   kernel_len  = cfg_data[KLEN_W-1:0];
          CFG_FRAME_LENGTH:  frame_len   = cfg_data[FLEN_W-1:0];
          CFG_TAPS_0_3:      tap_bank[0] = cfg_data;
          CFG_TAPS_4_7:      tap_bank[1] = cfg_data;
          CFG_TAPS_8_11:     tap_bank[2] = cfg_data;
          CFG_TAPS_12_14:    tap_bank[3] = {16'h0000, cfg_data[TAPS3_W-1:0]};
          default: ;
        endcase
      end
    end
    pending    <= expected_outputs.size();
    fail_count <= mismatches;
  end

endmodule

### bench/testbench.sv
module testbench
  import vmfc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 400;
  localparam int DRAIN_CYCLES   = TAP_COUNT + 5;
  localparam int WATCHDOG_LIMIT = 2000;

  // Indexes past the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic        [CFG_IDX_W-1:0]  cfg_index;
  logic        [CFG_DATA_W-1:0] cfg_data;
  logic                         sample_valid;
  logic                         sample_stall;
  logic signed [SAMPLE_W-1:0]   sample;
  logic                         result_valid;
  logic                         result_stall;
  logic signed [OUT_W-1:0]      filtered;
  logic        [POS_W-1:0]      out_position;
  logic                         saturated;
  logic                         frame_end;
  int                           fail_count;
  int                           pending;
  int                           quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  valid_mode_fir_convolver_unit u_top (.*);

  vmfc_checker u_checker (.*);

  // Mostly short gaps, a few long ones
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      4, 5, 6: return SAMPLE_W'($urandom_range(0, 511) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_taps();
    logic [CFG_DATA_W-1:0] word;
    for (int lane = 0; lane < 4; lane++) begin
      case ($urandom_range(0, 7))
        0: word[TAP_W*lane +: TAP_W] = 16'h8000;
        1: word[TAP_W*lane +: TAP_W] = 16'h7FFF;
        2, 3: word[TAP_W*lane +: TAP_W] = TAP_W'($urandom_range(0, 4095) - 2048);
        default: word[TAP_W*lane +: TAP_W] = TAP_W'($urandom);
      endcase
    end
    return word;
  endfunction

  // Leave cfg_valid high; the caller drops it after the burst
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Hold the sample until transfer, then idle for gap cycles
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, int gap);
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every expected output, then extra cycles
  task automatic settle(int extra);
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Result side back-pressure
  initial begin
    int run;
    int hold;
    result_stall = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 30);
      repeat (run) @(posedge clk);
      hold = idle_cycles();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (sample_valid && !sample_stall) ||
        (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] extreme_samples[4];
    logic        [CFG_DATA_W-1:0] data;
    int  items_sent;
    int  phase_len;
    bit  no_idle;
    bit  paused_once;

    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    sample_valid = 1'b0;
    sample       = '0;
    extreme_samples = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero taps, kernel 5, frame 64
    foreach (extreme_samples[i]) send_sample(extreme_samples[i], idle_cycles());
    sample_valid <= 1'b0;
    settle(DRAIN_CYCLES);

    // Full kernel of most negative taps on most negative samples; upper bits dropped
    write_register(CFG_KERNEL_TAPS,   64'hFFFF_FFFF_FFFF_FFFF);
    write_register(CFG_FRAME_LENGTH,  64'hFFFF_FFFF_FFFF_E00F);
    write_register(CFG_TAPS_0_3,      64'h8000_8000_8000_8000);
    write_register(CFG_TAPS_4_7,      64'h8000_8000_8000_8000);
    write_register(CFG_TAPS_8_11,     64'h8000_8000_8000_8000);
    write_register(CFG_TAPS_12_14,    64'hFFFF_8000_8000_8000);
    write_register(CFG_SPARE_6,       64'hFFFF_FFFF_FFFF_FFFF);
    write_register(CFG_SPARE_7,       64'h0000_0000_0000_0001);
    cfg_valid <= 1'b0;
    repeat (15) send_sample(16'sh8000, 0);
    sample_valid <= 1'b0;
    settle(DRAIN_CYCLES);

    // Zero kernel and frame lengths act as one
    write_register(CFG_KERNEL_TAPS,   64'hFFFF_FFFF_FFFF_FFF0);
    write_register(CFG_FRAME_LENGTH,  64'hFFFF_FFFF_FFFF_E000);
    write_register(CFG_TAPS_0_3,      64'h0000_0000_0000_7FFF);
    cfg_valid <= 1'b0;
    send_sample(16'sh7FFF, idle_cycles());
    send_sample(16'sh8000, idle_cycles());
    send_sample(16'sh0001, idle_cycles());
    sample_valid <= 1'b0;
    settle(DRAIN_CYCLES);

    // Kernel longer than the frame
    write_register(CFG_KERNEL_TAPS,   64'd7);
    write_register(CFG_FRAME_LENGTH,  64'd3);
    cfg_valid <= 1'b0;
    repeat (3) send_sample(rand_sample(), idle_cycles());
    sample_valid <= 1'b0;
    settle(DRAIN_CYCLES);

    // Frame above the maximum, then lowered mid-frame
    write_register(CFG_KERNEL_TAPS,   64'd2);
    write_register(CFG_FRAME_LENGTH,  64'h0000_0000_0000_1FFF);
    cfg_valid <= 1'b0;
    repeat (2) send_sample(rand_sample(), idle_cycles());
    sample_valid <= 1'b0;
    settle(DRAIN_CYCLES);
    write_register(CFG_FRAME_LENGTH, 64'd1);
    cfg_valid <= 1'b0;
    send_sample(rand_sample(), 0);
    sample_valid <= 1'b0;

    // Random phases of settings and samples
    items_sent  = 0;
    paused_once = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      settle(DRAIN_CYCLES);
      data = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: data[KLEN_W-1:0] = '0;
        1: data[KLEN_W-1:0] = 4'd15;
        2: data[KLEN_W-1:0] = 4'd1;
        default: data[KLEN_W-1:0] = KLEN_W'($urandom_range(1, 15));
      endcase
      write_register(CFG_KERNEL_TAPS, data);
      data = {$urandom, $urandom};
      case ($urandom_range(0, 11))
        0: data[FLEN_W-1:0] = 13'd1;
        1: data[FLEN_W-1:0] = 13'd4096;
        2: data[FLEN_W-1:0] = 13'h1FFF;
        3: data[FLEN_W-1:0] = '0;
        4: data[FLEN_W-1:0] = FLEN_W'($urandom_range(1, 4096));
        default: data[FLEN_W-1:0] = FLEN_W'($urandom_range(1, 32));
      endcase
      write_register(CFG_FRAME_LENGTH, data);
      if ($urandom_range(0, 1)) write_register(CFG_TAPS_0_3, rand_taps());
      if ($urandom_range(0, 1)) write_register(CFG_TAPS_4_7, rand_taps());
      if ($urandom_range(0, 1)) write_register(CFG_TAPS_8_11, rand_taps());
      if ($urandom_range(0, 1)) write_register(CFG_TAPS_12_14, rand_taps());
      if ($urandom_range(0, 7) == 0)
        write_register($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, {$urandom, $urandom});
      cfg_valid <= 1'b0;

      no_idle   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(8, 50);
      for (int i = 0; i < phase_len; i++) begin
        send_sample(rand_sample(), no_idle ? 0 : idle_cycles());
        items_sent++;
        // Pause the sender until the block has delivered everything
        if ((!paused_once && items_sent >= 20) || $urandom_range(0, 60) == 0) begin
          sample_valid <= 1'b0;
          settle(0);
          paused_once = 1'b1;
        end
      end
      sample_valid <= 1'b0;
    end

    settle(DRAIN_CYCLES);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
